@@ hdl/assert_macros.svh @@
// Assertion macros for the checker module of the timer bank.
// Expects clk_i and rst_ni to be visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hdl/ptb_pkg.sv @@
// Types shared by the periodic timer bank: operation codes and the
// transaction token that travels down the chain of timer cells.
package ptb_pkg;

  localparam int unsigned IdxW    = 4;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned MaskW   = 16;

  typedef enum logic [1:0] {
    ModeTick       = 2'd0,
    ModeRegister   = 2'd1,
    ModeUnregister = 2'd2,
    ModeChange     = 2'd3
  } mode_e;

  // Token carried from cell to cell; done marks a claimed or matched slot.
  typedef struct packed {
    mode_e                mode;
    logic [IdxW-1:0]      timer_index;
    logic [PeriodW-1:0]   period;
    logic                 done;
    logic [IdxW-1:0]      handle;
    logic [MaskW-1:0]     fire_mask;
  } token_t;

endpackage

@@ hdl/ptb_cell.sv @@
// One timer slot of the bank: running flag, reload value and countdown.
// Acts on the token passing through and hands it to the next cell.
// Depends on ptb_pkg.
module ptb_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  logic            valid_i,
  input  ptb_pkg::token_t tok_i,
  output logic            valid_o,
  output ptb_pkg::token_t tok_o
);

  localparam logic [ptb_pkg::MaskW-1:0] FireBit = ptb_pkg::MaskW'(1) << CELL_IDX;

  logic                        running_q, running_d;
  logic [ptb_pkg::PeriodW-1:0] reload_q, reload_d;
  logic [ptb_pkg::PeriodW-1:0] count_q, count_d;
  logic [ptb_pkg::PeriodW-1:0] count_dec;
  logic                        valid_q;
  ptb_pkg::token_t             tok_q, tok_d;
  logic                        idx_match;

  assign count_dec = count_q - ptb_pkg::PeriodW'(1);
  assign idx_match = (int'(tok_i.timer_index) == CELL_IDX);

  always_comb begin
    tok_d     = tok_i;
    running_d = running_q;
    reload_d  = reload_q;
    count_d   = count_q;
    if (valid_i) begin
      case (tok_i.mode)
        ptb_pkg::ModeTick: begin
          if (running_q) begin
            count_d = count_dec;
            if (count_dec == '0) begin
              count_d         = reload_q;
              tok_d.fire_mask = tok_i.fire_mask | FireBit;
            end
          end
        end
        ptb_pkg::ModeRegister: begin
          // lowest free slot wins: the first one the token meets
          if (!tok_i.done && !running_q) begin
            reload_d     = tok_i.period;
            count_d      = tok_i.period;
            running_d    = 1'b1;
            tok_d.done   = 1'b1;
            tok_d.handle = ptb_pkg::IdxW'(CELL_IDX);
          end
        end
        ptb_pkg::ModeUnregister: begin
          if (idx_match && running_q) begin
            running_d  = 1'b0;
            tok_d.done = 1'b1;
          end
        end
        ptb_pkg::ModeChange: begin
          if (idx_match && running_q) begin
            reload_d   = tok_i.period;
            tok_d.done = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (advance_i) begin
      running_q <= running_d;
      valid_q   <= valid_i;
    end
  end

  // slot contents are only read while running, so no reset needed
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      reload_q <= reload_d;
      count_q  <= count_d;
      tok_q    <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

@@ hdl/periodic_timer_bank.sv @@
// Top level of the periodic timer bank: a chain of ptb_cell slots fed
// from the input stream, closed by a registered output stage.
// Depends on ptb_pkg and ptb_cell.
//
// Usage:
//   Input stream (s_axis_*): one transaction per operation. tuser holds
//   the mode (tick, register, unregister, change period); tdata holds the
//   slot index and the period.
//   Output stream (m_axis_*): exactly one result transaction per input
//   transaction, in order: status, handle and fire mask.
//   Each transaction walks the chain, visiting slot 0 first, one slot
//   per cycle while the chain advances, so a register claims the lowest
//   free slot. Cell 0 registers a transaction at the accepting edge;
//   each later cell and then the output register take it in turn.
//   Throughput: one transaction per cycle unless stalled; transactions
//   follow each other down the chain; cells see them in arrival order.
//   Stall: when a result waits in the output register and the receiver
//   is not ready, the whole chain and the input freeze; nothing is lost.
//   Reset: all slots stop running and the chain and output empty; slot
//   periods and countdowns are loaded by register and need no clearing.
module periodic_timer_bank #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [3:0] timer_index, [35:4] period, [39:36] zero
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] mode
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] status, [4:1] handle, [20:5] fire_mask, [23:21] zero
  output logic [23:0] m_axis_tdata_o
);

  logic            advance;
  logic            chain_valid [NUM_TIMERS+1];
  ptb_pkg::token_t chain_tok   [NUM_TIMERS+1];

  logic            out_valid_q;
  logic            out_status_q, out_status_d;
  logic [3:0]      out_handle_q;
  logic [15:0]     out_mask_q;
  ptb_pkg::token_t tail;

  // Chain moves whenever the output register can take the tail token.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;

  // Token entering cell 0 comes straight from the input port.
  assign chain_valid[0]           = s_axis_tvalid_i;
  assign chain_tok[0].mode        = ptb_pkg::mode_e'(s_axis_tuser_i);
  assign chain_tok[0].timer_index = s_axis_tdata_i[3:0];
  assign chain_tok[0].period      = s_axis_tdata_i[35:4];
  assign chain_tok[0].done        = 1'b0;
  assign chain_tok[0].handle      = '0;
  assign chain_tok[0].fire_mask   = '0;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    ptb_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .advance_i(advance),
      .valid_i  (chain_valid[g]),
      .tok_i    (chain_tok[g]),
      .valid_o  (chain_valid[g+1]),
      .tok_o    (chain_tok[g+1])
    );
  end

  assign tail = chain_tok[NUM_TIMERS];

  // Tick always succeeds; other modes fail unless some cell acted.
  assign out_status_d = (tail.mode != ptb_pkg::ModeTick) && !tail.done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= chain_valid[NUM_TIMERS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_status_q <= out_status_d;
      out_handle_q <= out_status_d ? 4'd0 : tail.handle;
      out_mask_q   <= tail.fire_mask;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_mask_q, out_handle_q, out_status_q};

endmodule

@@ hdl/ptb_checker.sv @@
// Port-level checker for periodic_timer_bank, attached by bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ptb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o
);

  `ASSERT_CLK(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o), "result changed while stalled")
  `ASSERT_CLK(a_fire_ok, m_axis_tvalid_o && (m_axis_tdata_o[20:5] != 16'd0) |-> (m_axis_tdata_o[4:0] == 5'd0), "fire mask on a non-tick or failed result")
  `ASSERT_CLK(a_fail_clean, m_axis_tvalid_o && m_axis_tdata_o[0] |-> (m_axis_tdata_o[23:1] == 23'd0), "failure result carries a handle or mask")
  `ASSERT_ALWAYS(a_ready_free, !m_axis_tvalid_o |-> s_axis_tready_o, "input stalled with an empty output")

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (.*);

@@ sim/tb_periodic_timer_bank.sv @@
// Self-checking testbench for periodic_timer_bank: drives operation
// transactions on the input stream and checks every result transaction.
// Depends on ptb_pkg and the periodic_timer_bank RTL.
module tb_periodic_timer_bank;

  localparam int NumTimers  = 16;
  // Long receiver hold-off, well beyond the NUM_TIMERS + 1 deep pipeline.
  localparam int HoldCycles = 300;
  // Cycles to linger after the last result so that strays can show up.
  localparam int TailCycles = NumTimers + 8;
  // Watchdog in time units; the slowest legal run needs well under a tenth.
  localparam int WatchdogTime = 10_000_000;

  // One result transaction, fields as they leave the block.
  typedef struct packed {
    logic                       status;
    logic [ptb_pkg::IdxW-1:0]   handle;
    logic [ptb_pkg::MaskW-1:0]  fire_mask;
  } timer_result_t;

  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [39:0] s_data  = '0;
  logic [1:0]  s_user  = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;

  // Knobs for the idle behavior of both sides, set per test.
  bit tx_gaps_on  = 1'b1;
  bit rx_gaps_on  = 1'b1;
  bit rx_hold_req = 1'b0;

  // Predicted state of the bank, updated as each input transaction is accepted.
  logic [ptb_pkg::PeriodW-1:0] slot_reload [NumTimers];
  logic [ptb_pkg::PeriodW-1:0] slot_count  [NumTimers];
  logic [NumTimers-1:0]        slot_running = '0;
  int                          running_count = 0;

  timer_result_t expected_results[$];
  int            mismatch_count = 0;

  always #5 clk = ~clk;

  periodic_timer_bank #(
    .NUM_TIMERS(NumTimers)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor: applies one operation to the shadow bank and returns the result.
  // ---------------------------------------------------------------------------
  function automatic timer_result_t predict_timer_op(ptb_pkg::mode_e op,
                                                     logic [ptb_pkg::IdxW-1:0] idx,
                                                     logic [ptb_pkg::PeriodW-1:0] period);
    timer_result_t res;
    bit            claimed;
    int            i;
    res     = '0;
    claimed = 1'b0;
    case (op)
      ptb_pkg::ModeTick: begin
        // Every running countdown steps down; zero means expire and reload.
        // A period of zero wraps through 0xFFFFFFFF here on its own.
        for (i = 0; i < NumTimers; i++) begin
          if (slot_running[i]) begin
            slot_count[i] = slot_count[i] - 32'd1;
            if (slot_count[i] == '0) begin
              slot_count[i]    = slot_reload[i];
              res.fire_mask[i] = 1'b1;
            end
          end
        end
      end
      ptb_pkg::ModeRegister: begin
        // Lowest free slot wins; a full bank answers failure.
        res.status = 1'b1;
        if (running_count < NumTimers) begin
          for (i = 0; i < NumTimers; i++) begin
            if (!claimed && !slot_running[i]) begin
              claimed         = 1'b1;
              slot_reload[i]  = period;
              slot_count[i]   = period;
              slot_running[i] = 1'b1;
              running_count++;
              res.status = 1'b0;
              res.handle = 4'(i);
            end
          end
        end
      end
      default: begin
        // Unregister and change period both need a running slot.
        if (!slot_running[idx]) begin
          res.status = 1'b1;
        end else if (op == ptb_pkg::ModeUnregister) begin
          slot_running[idx] = 1'b0;
          running_count--;
        end else begin
          slot_reload[idx] = period;
        end
      end
    endcase
    return res;
  endfunction

  // Idle length: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Periods: small ones so that slots expire often, plus the extremes and
  // full-width random values so that every period bit toggles.
  function automatic logic [ptb_pkg::PeriodW-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5)  return '0;
    if (r < 10) return 32'hFFFF_FFFF;
    if (r < 25) return 32'($urandom);
    return 32'($urandom_range(1, 9));
  endfunction

  // Mostly a running slot, sometimes any slot to hit the not-running case.
  function automatic logic [ptb_pkg::IdxW-1:0] pick_slot();
    logic [ptb_pkg::IdxW-1:0] idx;
    idx = 4'($urandom_range(0, NumTimers - 1));
    if (slot_running != '0 && $urandom_range(0, 9) < 8) begin
      while (!slot_running[idx]) idx = 4'($urandom_range(0, NumTimers - 1));
    end
    return idx;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one input transaction, with an optional idle gap in front.
  // tdata = {4'b0, period, timer_index}, tuser = mode.
  // ---------------------------------------------------------------------------
  task automatic send_op(ptb_pkg::mode_e op, logic [ptb_pkg::IdxW-1:0] idx,
                         logic [ptb_pkg::PeriodW-1:0] period);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {4'b0000, period, idx};
    s_user  <= op;
    do @(posedge clk); while (!s_ready);
    expected_results.push_back(predict_timer_op(op, idx, period));
  endtask

  // Random operation drawn from a mix that keeps the bank busy and firing.
  task automatic send_random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)      send_op(ptb_pkg::ModeTick, 4'($urandom), 32'($urandom));
    else if (r < 70) send_op(ptb_pkg::ModeRegister, 4'($urandom), pick_period());
    else if (r < 87) send_op(ptb_pkg::ModeUnregister, pick_slot(), 32'($urandom));
    else             send_op(ptb_pkg::ModeChange, pick_slot(), pick_period());
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : rx_driver
    int stall;
    stall = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = HoldCycles;
      end else if (stall == 0 && rx_gaps_on && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
      end
      m_ready <= (stall == 0);
      if (stall > 0) stall--;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void log_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : result_check
    timer_result_t got;
    timer_result_t want;
    if (rst_n && m_valid && m_ready) begin
      got.status    = m_data[0];
      got.handle    = m_data[4:1];
      got.fire_mask = m_data[20:5];
      if (expected_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result status=%0b handle=%0d mask=%04h",
                               got.status, got.handle, got.fire_mask));
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status || got.handle !== want.handle ||
            got.fire_mask !== want.fire_mask) begin
          log_mismatch($sformatf({"expected status=%0b handle=%0d mask=%04h, ",
                                  "got status=%0b handle=%0d mask=%04h"},
                                 want.status, want.handle, want.fire_mask,
                                 got.status, got.handle, got.fire_mask));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Tick on an empty bank, the period extremes, expiry, change period on a
  // running slot, unregister twice and change on a stopped slot, slot reuse.
  task automatic test_directed_basics();
    send_op(ptb_pkg::ModeTick, 4'hF, 32'hFFFF_FFFF);
    send_op(ptb_pkg::ModeRegister, 4'h0, 32'd1);
    send_op(ptb_pkg::ModeRegister, 4'h0, 32'd0);
    send_op(ptb_pkg::ModeRegister, 4'hF, 32'hFFFF_FFFF);
    send_op(ptb_pkg::ModeRegister, 4'h0, 32'd3);
    send_op(ptb_pkg::ModeTick, 4'h0, 32'd0);
    send_op(ptb_pkg::ModeTick, 4'h0, 32'd0);
    send_op(ptb_pkg::ModeChange, 4'd3, 32'd2);
    send_op(ptb_pkg::ModeUnregister, 4'd1, 32'd0);
    send_op(ptb_pkg::ModeUnregister, 4'd1, 32'd0);
    send_op(ptb_pkg::ModeChange, 4'd1, 32'd7);
    send_op(ptb_pkg::ModeRegister, 4'h0, 32'd2);
  endtask

  // Fill every free slot, then one register too many, a tick on a full bank,
  // and the top slot index addressed directly.
  task automatic test_bank_full();
    while (running_count < NumTimers) send_op(ptb_pkg::ModeRegister, 4'h0, pick_period());
    send_op(ptb_pkg::ModeRegister, 4'h0, 32'd5);
    send_op(ptb_pkg::ModeTick, 4'h0, 32'd0);
    send_op(ptb_pkg::ModeChange, 4'hF, 32'hFFFF_FFFF);
    send_op(ptb_pkg::ModeUnregister, 4'hF, 32'd0);
    send_op(ptb_pkg::ModeChange, 4'hF, 32'd1);
  endtask

  task automatic test_random_traffic(int count, bit tx_gaps, bit rx_gaps);
    tx_gaps_on = tx_gaps;
    rx_gaps_on = rx_gaps;
    repeat (count) send_random_op();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // transactions back to back, so the chain fills and the input stalls.
  task automatic test_backpressure();
    tx_gaps_on  = 1'b0;
    rx_gaps_on  = 1'b1;
    rx_hold_req = 1'b1;
    repeat (80) send_random_op();
  endtask

  // Stop every running slot, then ticks on the empty bank.
  task automatic test_drain_bank();
    int i;
    tx_gaps_on = 1'b1;
    for (i = 0; i < NumTimers; i++) begin
      if (slot_running[i]) send_op(ptb_pkg::ModeUnregister, 4'(i), 32'($urandom));
    end
    repeat (3) send_op(ptb_pkg::ModeTick, 4'($urandom), 32'($urandom));
  endtask

  initial begin : watchdog
    #(WatchdogTime);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_basics();
    test_bank_full();
    test_random_traffic(420, 1'b1, 1'b1);
    test_random_traffic(300, 1'b0, 1'b0);
    test_backpressure();
    test_random_traffic(300, 1'b1, 1'b0);
    test_drain_bank();
    test_random_traffic(100, 1'b0, 1'b1);

    @(negedge clk);
    s_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
